// ----- rtl/core/ssi_pkg.sv -----
package ssi_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FIELD_COUNT = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    CASE_CROSS         = 3'd0,
    CASE_COLL_OVERLAP  = 3'd1,
    CASE_COLL_DISJOINT = 3'd2,
    CASE_PARALLEL      = 3'd3,
    CASE_MISS          = 3'd4
  } case_code_t;

  typedef struct packed {
    logic rxs_zero;
    logic qpxr_zero;
    logic coll_hit;
    logic unit_ok;
  } flags_t;

endpackage

// ----- rtl/core/ssi_cross.sv -----
module ssi_cross #(
  parameter int unsigned COORD_BITS = ssi_pkg::COORD_BITS_DEF,
  localparam int unsigned DIFF_W = COORD_BITS + 1,
  localparam int unsigned P_W = 2 * DIFF_W,
  localparam int unsigned SUM_W = P_W + 1,
  localparam int unsigned IN_W = ssi_pkg::FIELD_COUNT * COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IN_W-1:0]         in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] rxs,
  output logic signed [SUM_W-1:0] qpxr,
  output logic signed [SUM_W-1:0] qpxs,
  output logic signed [SUM_W-1:0] qpr,
  output logic signed [SUM_W-1:0] pqs,
  output logic signed [SUM_W-1:0] rr,
  output logic signed [SUM_W-1:0] ss
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic signed [DIFF_W-1:0] ax, ay, ex, ey, bx, by, fx, fy;
  logic signed [DIFF_W-1:0] rx, ry, sx, sy, dx, dy;

  logic signed [P_W-1:0] p_rxsy, p_rysx, p_dxry, p_dyrx, p_dxsy, p_dysx;
  logic signed [P_W-1:0] p_dxrx, p_dyry, p_dxsx, p_dysy;
  logic signed [P_W-1:0] p_rxrx, p_ryry, p_sxsx, p_sysy;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // sign-extended coordinates
  assign ax = DIFF_W'(signed'(in_data[0*COORD_BITS +: COORD_BITS]));
  assign ay = DIFF_W'(signed'(in_data[1*COORD_BITS +: COORD_BITS]));
  assign ex = DIFF_W'(signed'(in_data[2*COORD_BITS +: COORD_BITS]));
  assign ey = DIFF_W'(signed'(in_data[3*COORD_BITS +: COORD_BITS]));
  assign bx = DIFF_W'(signed'(in_data[4*COORD_BITS +: COORD_BITS]));
  assign by = DIFF_W'(signed'(in_data[5*COORD_BITS +: COORD_BITS]));
  assign fx = DIFF_W'(signed'(in_data[6*COORD_BITS +: COORD_BITS]));
  assign fy = DIFF_W'(signed'(in_data[7*COORD_BITS +: COORD_BITS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1: edge vectors
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      rx <= ex - ax;
      ry <= ey - ay;
      sx <= fx - bx;
      sy <= fy - by;
      dx <= bx - ax;
      dy <= by - ay;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p_rxsy <= P_W'(rx) * P_W'(sy);
      p_rysx <= P_W'(ry) * P_W'(sx);
      p_dxry <= P_W'(dx) * P_W'(ry);
      p_dyrx <= P_W'(dy) * P_W'(rx);
      p_dxsy <= P_W'(dx) * P_W'(sy);
      p_dysx <= P_W'(dy) * P_W'(sx);
      p_dxrx <= P_W'(dx) * P_W'(rx);
      p_dyry <= P_W'(dy) * P_W'(ry);
      p_dxsx <= P_W'(dx) * P_W'(sx);
      p_dysy <= P_W'(dy) * P_W'(sy);
      p_rxrx <= P_W'(rx) * P_W'(rx);
      p_ryry <= P_W'(ry) * P_W'(ry);
      p_sxsx <= P_W'(sx) * P_W'(sx);
      p_sysy <= P_W'(sy) * P_W'(sy);
    end
  end

  // stage 3: cross and dot products
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      rxs  <= SUM_W'(p_rxsy) - SUM_W'(p_rysx);
      qpxr <= SUM_W'(p_dxry) - SUM_W'(p_dyrx);
      qpxs <= SUM_W'(p_dxsy) - SUM_W'(p_dysx);
      qpr  <= SUM_W'(p_dxrx) + SUM_W'(p_dyry);
      pqs  <= -SUM_W'(p_dxsx) - SUM_W'(p_dysy);
      rr   <= SUM_W'(p_rxrx) + SUM_W'(p_ryry);
      ss   <= SUM_W'(p_sxsx) + SUM_W'(p_sysy);
    end
  end

endmodule

// ----- rtl/core/segment_segment_intersect_unit.sv -----
// Segment pair intersection test. Each input word carries two segments as eight
// two's complement coordinates of COORD_BITS bits; each output word carries hit
// and a case code (crossing, collinear overlap, collinear disjoint, parallel, no
// crossing). The test is exact integer arithmetic with no division. The pipeline
// has five register stages (edge vectors, products, cross and dot sums, compare
// flags, result), and one pair is accepted every cycle while the output side
// keeps up. Results leave in input order; a stall on the output fills the empty
// stages first.
module segment_segment_intersect_unit #(
  parameter int unsigned COORD_BITS = ssi_pkg::COORD_BITS_DEF,
  localparam int unsigned SUM_W = 2 * (COORD_BITS + 1) + 1,
  localparam int unsigned IN_W = ssi_pkg::FIELD_COUNT * COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // a_begin_x, a_begin_y, a_end_x, a_end_y, b_begin_x, b_begin_y, b_end_x, b_end_y
  input  logic [IN_W-1:0]                    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // hit, case_code, zero fill
  output logic [ssi_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  logic cross_valid, cross_ready;
  logic signed [SUM_W-1:0] rxs, qpxr, qpxs, qpr, pqs, rr, ss;

  logic v4, v5, rdy4, rdy5;
  ssi_pkg::flags_t flags, flags4;
  logic unit_t, unit_u;
  logic hit_next, hit;
  ssi_pkg::case_code_t code_next, code;

  ssi_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .rxs       (rxs),
    .qpxr      (qpxr),
    .qpxs      (qpxs),
    .qpr       (qpr),
    .pqs       (pqs),
    .rr        (rr),
    .ss        (ss)
  );

  assign rdy5 = !v5 || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign cross_ready = rdy4;

  // ratio in [0,1] tested by sign and magnitude
  always_comb begin
    if (rxs > 0) begin
      unit_t = (qpxs >= 0) && (qpxs <= rxs);
      unit_u = (qpxr >= 0) && (qpxr <= rxs);
    end else begin
      unit_t = (qpxs <= 0) && (qpxs >= rxs);
      unit_u = (qpxr <= 0) && (qpxr >= rxs);
    end
    flags.rxs_zero  = (rxs == '0);
    flags.qpxr_zero = (qpxr == '0);
    flags.coll_hit  = ((qpr >= 0) && (qpr <= rr)) || ((pqs >= 0) && (pqs <= ss));
    flags.unit_ok   = unit_t && unit_u;
  end

  always_comb begin
    if (flags4.rxs_zero && flags4.qpxr_zero) begin
      hit_next  = flags4.coll_hit;
      code_next = flags4.coll_hit ? ssi_pkg::CASE_COLL_OVERLAP
                                  : ssi_pkg::CASE_COLL_DISJOINT;
    end else if (flags4.rxs_zero) begin
      hit_next  = 1'b0;
      code_next = ssi_pkg::CASE_PARALLEL;
    end else if (flags4.unit_ok) begin
      hit_next  = 1'b1;
      code_next = ssi_pkg::CASE_CROSS;
    end else begin
      hit_next  = 1'b0;
      code_next = ssi_pkg::CASE_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy4) v4 <= cross_valid;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && cross_valid) begin
      flags4 <= flags;
    end
    if (rdy5 && v4) begin
      hit  <= hit_next;
      code <= code_next;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {{(ssi_pkg::OUT_TDATA_W - 4){1'b0}}, code, hit};

endmodule

// ----- rtl/core/ssi_checker.sv -----
module ssi_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ssi_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic       hit;
  logic [2:0] code;

  assign hit  = m_tdata[0];
  assign code = m_tdata[3:1];

  // hit agrees with the case code
  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hit == ((code == ssi_pkg::CASE_CROSS) ||
                          (code == ssi_pkg::CASE_COLL_OVERLAP))))
    else $error("hit does not match case code");

  // fill bits stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ssi_pkg::OUT_TDATA_W-1:4] == '0))
    else $error("nonzero fill bits in output word");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word changed under stall");

endmodule

bind segment_segment_intersect_unit ssi_checker u_ssi_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
module testbench;

  localparam int CW = ssi_pkg::COORD_BITS_DEF;
  localparam int IN_W = ssi_pkg::FIELD_COUNT * CW;
  localparam int OUT_W = ssi_pkg::OUT_TDATA_W;
  localparam int RANDOM_PAIRS = 1600;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic hit;
    ssi_pkg::case_code_t code;
  } verdict_t;

  class verdict_tracker;
    verdict_t verdicts_due[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // num/den within [0,1], den nonzero
    function bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
    endfunction

    function verdict_t classify(logic [IN_W-1:0] word);
      longint c[8];
      longint rx, ry, sx, sy, dx, dy;
      longint rxs, qpxr, qpxs, qpr, pqs, rr, ss;
      verdict_t v;
      for (int i = 0; i < 8; i++) c[i] = longint'($signed(word[i*CW +: CW]));
      rx = c[2] - c[0];
      ry = c[3] - c[1];
      sx = c[6] - c[4];
      sy = c[7] - c[5];
      dx = c[4] - c[0];
      dy = c[5] - c[1];
      rxs = rx * sy - ry * sx;
      qpxr = dx * ry - dy * rx;
      qpxs = dx * sy - dy * sx;
      if (rxs == 0 && qpxr == 0) begin
        qpr = dx * rx + dy * ry;
        pqs = (-dx) * sx + (-dy) * sy;
        rr = rx * rx + ry * ry;
        ss = sx * sx + sy * sy;
        if ((qpr >= 0 && qpr <= rr) || (pqs >= 0 && pqs <= ss)) begin
          v.hit = 1'b1;
          v.code = ssi_pkg::CASE_COLL_OVERLAP;
        end else begin
          v.hit = 1'b0;
          v.code = ssi_pkg::CASE_COLL_DISJOINT;
        end
      end else if (rxs == 0) begin
        v.hit = 1'b0;
        v.code = ssi_pkg::CASE_PARALLEL;
      end else if (in_unit(qpxs, rxs) && in_unit(qpxr, rxs)) begin
        v.hit = 1'b1;
        v.code = ssi_pkg::CASE_CROSS;
      end else begin
        v.hit = 1'b0;
        v.code = ssi_pkg::CASE_MISS;
      end
      return v;
    endfunction

    function void note_pair(logic [IN_W-1:0] word);
      verdicts_due = {verdicts_due, classify(word)};
    endfunction

    function void check_word(logic [OUT_W-1:0] word);
      verdict_t want;
      logic got_hit;
      logic [2:0] got_code;
      got_hit = word[0];
      got_code = word[3:1];
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: hit=%0d case_code=%0d", got_hit, got_code);
        return;
      end
      want = verdicts_due.pop_front();
      if (got_hit !== want.hit || got_code !== want.code) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected hit=%0d case_code=%0d, got hit=%0d case_code=%0d",
                   want.hit, want.code, got_hit, got_code);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;

  verdict_tracker tracker = new();
  bit calm;
  int idle_cycles;
  int stall_left;

  segment_segment_intersect_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // word counting on both sides
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tracker.note_pair(s_tdata);
    if (!rst && m_tvalid && m_tready) tracker.check_word(m_tdata);
    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // output back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!calm) stall_left = gap_len();
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_pair(input shortint ax, ay, ex, ey, bx, by, qx, qy);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {qy, qx, by, bx, ey, ex, ay, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int kind, px, py, dx, dy, ox, oy, k[4];
    shortint c[8];
    shortint corner[7];
    corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    kind = $urandom_range(9);
    px = rnd(-1000, 1000);
    py = rnd(-1000, 1000);
    dx = rnd(-20, 20);
    dy = rnd(-20, 20);
    ox = rnd(-5, 5);
    oy = rnd(-5, 5);
    for (int i = 0; i < 4; i++) k[i] = rnd(-40, 40);
    case (kind)
      0, 1: begin
        for (int i = 0; i < 8; i++) c[i] = shortint'($urandom_range(65535));
      end
      2, 3: begin
        for (int i = 0; i < 8; i++) c[i] = shortint'(rnd(-6, 6));
      end
      4, 5, 6: begin
        // points on one line; parallel offset on the second segment for kind 6
        if (kind != 6) begin
          ox = 0;
          oy = 0;
        end
        c[0] = shortint'(px + k[0] * dx);
        c[1] = shortint'(py + k[0] * dy);
        c[2] = shortint'(px + k[1] * dx);
        c[3] = shortint'(py + k[1] * dy);
        c[4] = shortint'(px + ox + k[2] * dx);
        c[5] = shortint'(py + oy + k[2] * dy);
        c[6] = shortint'(px + ox + k[3] * dx);
        c[7] = shortint'(py + oy + k[3] * dy);
      end
      7: begin
        for (int i = 0; i < 8; i++) c[i] = corner[$urandom_range(6)];
      end
      8: begin
        // degenerate segments
        for (int i = 0; i < 8; i++) c[i] = shortint'(rnd(-8, 8));
        if ($urandom_range(1)) begin
          c[2] = c[0];
          c[3] = c[1];
        end else begin
          c[6] = c[4];
          c[7] = c[5];
        end
      end
      default: begin
        for (int i = 0; i < 8; i++) c[i] = shortint'(rnd(-1024, 1023));
      end
    endcase
    send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
    stall_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(0, 0, 4, 4, 0, 4, 4, 0);
    send_pair(0, 4, 4, 0, 0, 0, 4, 4);
    send_pair(0, 0, 4, 0, 4, 0, 4, 5);
    send_pair(0, 0, 4, 0, 2, 0, 2, 3);
    send_pair(0, 0, 1, 1, 3, 0, 4, -5);
    send_pair(0, 0, 4, 0, 5, -1, 5, 1);
    send_pair(0, 0, 4, 0, 2, 0, 6, 0);
    send_pair(0, 0, 2, 0, 5, 0, 8, 0);
    send_pair(0, 0, 2, 0, 2, 0, 5, 0);
    send_pair(1, 0, 2, 0, 5, 0, -3, 0);
    // overlapping, but neither start lies on the other segment
    send_pair(0, 0, 4, 0, 6, 0, 2, 0);
    send_pair(0, 0, 4, 0, 0, 1, 4, 1);
    send_pair(0, 0, 4, 4, 2, 2, 2, 2);
    send_pair(0, 0, 4, 4, 1, 3, 1, 3);
    send_pair(7, -3, 7, -3, -9, 5, 12, 30);
    send_pair(1, 1, 1, 1, 5, 5, 5, 5);
    send_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
    send_pair(-32768, 0, -1, 0, 0, 0, 32767, 0);
    send_pair(-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      calm = (i % 300) < 60;
      if (i == RANDOM_PAIRS / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
      end
      send_random();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
